/* design/irn_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irn_pkg
// Shared types and constant tables for the integer to Roman numeral block.
// ---------------------------------------------------------------------------
package irn_pkg;

  localparam int VALUE_W   = 12;
  localparam int SYMBOL_W  = 7;
  localparam int NUM_TERMS = 13;
  localparam int TERM_W    = $clog2(NUM_TERMS);
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  localparam logic [SYMBOL_W-1:0] CH_NONE = 7'd0;
  localparam logic [SYMBOL_W-1:0] CH_I    = 7'd73;
  localparam logic [SYMBOL_W-1:0] CH_V    = 7'd86;
  localparam logic [SYMBOL_W-1:0] CH_X    = 7'd88;
  localparam logic [SYMBOL_W-1:0] CH_L    = 7'd76;
  localparam logic [SYMBOL_W-1:0] CH_C    = 7'd67;
  localparam logic [SYMBOL_W-1:0] CH_D    = 7'd68;
  localparam logic [SYMBOL_W-1:0] CH_M    = 7'd77;

  // Greedy term table, largest first. Subtractive terms carry two characters.
  localparam logic [VALUE_W-1:0] TERM_VAL [NUM_TERMS] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam logic [SYMBOL_W-1:0] TERM_CH0 [NUM_TERMS] = '{
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  localparam logic [SYMBOL_W-1:0] TERM_CH1 [NUM_TERMS] = '{
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L,
    CH_NONE, CH_X, CH_NONE, CH_V, CH_NONE
  };
  localparam logic TERM_PAIR [NUM_TERMS] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
  };

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* design/irn_channels.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irn channels
// Valid/ready channels for the integer request and the character results.
// ---------------------------------------------------------------------------
interface irn_value_if;
  logic                         valid;
  logic                         ready;
  logic [irn_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface irn_symbol_if;
  logic                         valid;
  logic                         ready;
  logic [irn_pkg::SYMBOL_W-1:0] symbol;
  logic                         last;
  logic                         range_error;

  modport source (output valid, output symbol, output last, output range_error,
                  input ready);
  modport sink   (input valid, input symbol, input last, input range_error,
                  output ready);
endinterface

/* design/irn_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irn_ctrl
// Sequencer: takes a request, steps the datapath one character per
// handshake, and after the final character takes the next request or idles.
// ---------------------------------------------------------------------------
module irn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  irn_pkg::status_t status,
  output irn_pkg::cmd_t    cmd
);

  irn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      irn_pkg::ST_IDLE: begin
        if (in_valid) state_next = irn_pkg::ST_EMIT;
      end
      irn_pkg::ST_EMIT: begin
        if (out_ready && status.last && !in_valid) state_next = irn_pkg::ST_IDLE;
      end
      default: state_next = irn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = 1'b0;
    in_ready  = 1'b0;
    unique case (state)
      irn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      irn_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        // take the next request as the final character leaves
        in_ready  = out_ready && status.last;
      end
      default: begin
        out_valid = 1'b0;
        in_ready  = 1'b0;
      end
    endcase
    cmd.load    = in_valid && in_ready;
    cmd.advance = out_valid && out_ready;
  end

endmodule

/* design/irn_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irn_datapath
// Remainder register and greedy term selection; produces the current
// character and its last/error marks.
// ---------------------------------------------------------------------------
module irn_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  irn_pkg::cmd_t                cmd,
  input  logic [irn_pkg::VALUE_W-1:0]  value,
  output irn_pkg::status_t             status,
  output logic [irn_pkg::SYMBOL_W-1:0] symbol,
  output logic                         last,
  output logic                         range_error
);

  logic [irn_pkg::VALUE_W-1:0] rem;
  logic                        phase;
  logic                        err;

  logic [irn_pkg::TERM_W-1:0]  sel;
  logic [irn_pkg::VALUE_W-1:0] term;
  logic                        pair;
  logic                        term_done;

  // largest term not above the remainder
  always_comb begin
    sel = irn_pkg::TERM_W'(irn_pkg::NUM_TERMS - 1);
    for (int i = irn_pkg::NUM_TERMS - 1; i >= 0; i--) begin
      if (rem >= irn_pkg::TERM_VAL[i]) sel = irn_pkg::TERM_W'(i);
    end
  end

  always_comb begin
    term      = irn_pkg::TERM_VAL[sel];
    pair      = irn_pkg::TERM_PAIR[sel];
    term_done = !pair || phase;
    if (err) begin
      symbol = irn_pkg::CH_NONE;
    end else if (phase) begin
      symbol = irn_pkg::TERM_CH1[sel];
    end else begin
      symbol = irn_pkg::TERM_CH0[sel];
    end
    last        = err || (term_done && (rem == term));
    range_error = err;
    status.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem   <= '0;
      phase <= 1'b0;
      err   <= 1'b0;
    end else if (cmd.load) begin
      rem   <= value;
      phase <= 1'b0;
      err   <= (value == '0) || (value > irn_pkg::VALUE_MAX);
    end else if (cmd.advance) begin
      if (term_done) begin
        rem   <= rem - term;
        phase <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    err |-> last)
    else $error("error result not marked last");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && !err) |-> (rem != '0) && (rem >= term))
    else $error("remainder below selected term");

  a_more_left: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && !cmd.load && !err && !last) |=> (rem != '0))
    else $error("remainder exhausted before last character");

  a_load_clears_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !phase)
    else $error("second-character phase survived a new request");

endmodule

/* design/integer_to_roman_numeral.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit integer to its Roman numeral as a stream of ASCII
// characters.
// ---------------------------------------------------------------------------
// A request carrying 1 to 3999 yields one result per character of the
// subtractive numeral, most significant first, with last set on the final
// one; 0 or 4000..4095 yields a single result with symbol 0, last and
// range_error set. A numeral has 1 to 15 characters (15 for 3888). The
// greedy remainder step produces one character per cycle unless the result
// side stalls, and the next request is taken in the cycle the final
// character is taken.
// ---------------------------------------------------------------------------
module integer_to_roman_numeral (
  input  logic   clk,
  input  logic   rst,
  irn_value_if.sink    request,
  irn_symbol_if.source result
);

  irn_pkg::cmd_t    cmd;
  irn_pkg::status_t status;

  irn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  irn_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (request.value),
    .status      (status),
    .symbol      (result.symbol),
    .last        (result.last),
    .range_error (result.range_error)
  );

endmodule

/* sim/integer_to_roman_numeral_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_roman_numeral_tb
// Self-checking bench for the integer to Roman numeral converter. A short
// table of requests covers the range ends, every digit form and the range
// errors. Random requests follow, with random gaps on the request side and
// random stalls on the result side. Every result character is checked
// against the table's text, an error mark or the bench's decade converter.
// ---------------------------------------------------------------------------
module integer_to_roman_numeral_tb;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 255;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TEXT,
    ROW_ERROR
  } row_kind_t;

  typedef struct {
    logic [irn_pkg::VALUE_W-1:0] value;
    row_kind_t                   kind;
    string                       text;
  } stim_row_t;

  typedef struct packed {
    logic [irn_pkg::SYMBOL_W-1:0] symbol;
    logic                         last;
    logic                         range_error;
  } roman_char_t;

  logic clk;
  logic rst;

  irn_value_if  req_if ();
  irn_symbol_if res_if ();

  integer_to_roman_numeral DUT (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  // Side information that travels with each request
  row_kind_t   req_kind;
  string       req_text;

  roman_char_t expected_chars[$];
  stim_row_t   directed_rows[];
  int          mismatches;
  int          idle_cycles;
  bit          hold_results;
  bit          no_idling;

  initial begin
    clk = 1'b0;
  end

  always #HALF_PERIOD clk = ~clk;

  // Spell a value as a subtractive numeral, one decade at a time
  function automatic string roman_text(input logic [irn_pkg::VALUE_W-1:0] v);
    string units;
    string fives;
    string tens;
    string s;
    int    n;
    int    d;
    int    dec;
    units = "MCXI";
    fives = " DLV";
    tens  = " MCX";
    s     = "";
    n     = int'(v);
    for (dec = 0; dec < 4; dec++) begin
      case (dec)
        0:       d = n / 1000;
        1:       d = (n / 100) % 10;
        2:       d = (n / 10) % 10;
        default: d = n % 10;
      endcase
      if (d == 9) begin
        s = {s, units.substr(dec, dec), tens.substr(dec, dec)};
      end else if (d == 4) begin
        s = {s, units.substr(dec, dec), fives.substr(dec, dec)};
      end else begin
        if (d >= 5) begin
          s = {s, fives.substr(dec, dec)};
          d -= 5;
        end
        for (int k = 0; k < d; k++) s = {s, units.substr(dec, dec)};
      end
    end
    return s;
  endfunction

  function automatic void queue_numeral(input logic [irn_pkg::VALUE_W-1:0] v,
                                        input row_kind_t kind, input string text);
    string       s;
    roman_char_t c;
    if (kind == ROW_ERROR ||
        (kind == ROW_PREDICT && (v == '0 || v > irn_pkg::VALUE_MAX))) begin
      c.symbol      = irn_pkg::CH_NONE;
      c.last        = 1'b1;
      c.range_error = 1'b1;
      expected_chars.push_back(c);
    end else begin
      s = (kind == ROW_TEXT) ? text : roman_text(v);
      for (int i = 0; i < s.len(); i++) begin
        c.symbol      = irn_pkg::SYMBOL_W'(s[i]);
        c.last        = (i == s.len() - 1);
        c.range_error = 1'b0;
        expected_chars.push_back(c);
      end
    end
  endfunction

  // Record accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin
    roman_char_t e;
    if (!rst) begin
      if (req_if.valid && req_if.ready) queue_numeral(req_if.value, req_kind, req_text);
      if (res_if.valid && res_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected result symbol=%0d last=%0b range_error=%0b",
                   $time, res_if.symbol, res_if.last, res_if.range_error);
          mismatches++;
        end else begin
          e = expected_chars.pop_front();
          if (res_if.symbol !== e.symbol || res_if.last !== e.last ||
              res_if.range_error !== e.range_error) begin
            $display("%0t: mismatch expected symbol=%0d last=%0b range_error=%0b, got symbol=%0d last=%0b range_error=%0b",
                     $time, e.symbol, e.last, e.range_error,
                     res_if.symbol, res_if.last, res_if.range_error);
            mismatches++;
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int r;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (no_idling) begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          res_if.ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 9) begin
          res_if.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          res_if.ready <= 1'b0;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  function automatic int request_gap();
    int r;
    if (no_idling) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic [irn_pkg::VALUE_W-1:0] v,
                              input row_kind_t kind, input string text);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.value <= v;
    req_kind     <= kind;
    req_text     <= text;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  function automatic logic [irn_pkg::VALUE_W-1:0] random_value();
    if ($urandom_range(0, 99) < 8) begin
      return ($urandom_range(0, 1) == 0) ?
             '0 : irn_pkg::VALUE_W'($urandom_range(4000, 4095));
    end
    if ($urandom_range(0, 9) == 0) return irn_pkg::VALUE_W'($urandom_range(0, 4095));
    return irn_pkg::VALUE_W'($urandom_range(1, 3999));
  endfunction

  initial begin
    mismatches   = 0;
    idle_cycles  = 0;
    hold_results = 1'b0;
    no_idling    = 1'b0;
    req_if.valid <= 1'b0;
    req_if.value <= '0;
    req_kind     <= ROW_PREDICT;
    req_text     <= "";
    rst          <= 1'b1;
    directed_rows = '{
      '{12'd1,    ROW_TEXT,    "I"},
      '{12'd3999, ROW_TEXT,    "MMMCMXCIX"},
      '{12'd3888, ROW_TEXT,    "MMMDCCCLXXXVIII"},
      '{12'd0,    ROW_ERROR,   ""},
      '{12'd4000, ROW_ERROR,   ""},
      '{12'd4095, ROW_ERROR,   ""},
      '{12'd4,    ROW_TEXT,    "IV"},
      '{12'd9,    ROW_TEXT,    "IX"},
      '{12'd5,    ROW_TEXT,    "V"},
      '{12'd40,   ROW_TEXT,    "XL"},
      '{12'd90,   ROW_TEXT,    "XC"},
      '{12'd400,  ROW_TEXT,    "CD"},
      '{12'd900,  ROW_TEXT,    "CM"},
      '{12'd1000, ROW_TEXT,    "M"},
      '{12'd3000, ROW_TEXT,    "MMM"},
      '{12'd6,    ROW_PREDICT, ""},
      '{12'd7,    ROW_PREDICT, ""},
      '{12'd8,    ROW_PREDICT, ""},
      '{12'd444,  ROW_PREDICT, ""},
      '{12'd999,  ROW_PREDICT, ""},
      '{12'd1994, ROW_PREDICT, ""},
      '{12'd2048, ROW_PREDICT, ""},
      '{12'd1365, ROW_PREDICT, ""},
      '{12'd2730, ROW_PREDICT, ""},
      '{12'd3003, ROW_PREDICT, ""}
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].value, directed_rows[i].kind, directed_rows[i].text);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Stall the result side long enough to back up the request side
      if (n == 60) hold_results = 1'b1;
      // Drain completely before going on
      if (n == 150) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
      end
      no_idling = (n >= 200 && n < 240);
      send_request(random_value(), ROW_PREDICT, "");
    end
    req_if.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
